// ----- sv/carc_pkg.sv -----
// ----------------------------------------------------------------------------
// carc_pkg: shared types and constants of the copy/add run coalescer
// Holds the result record and the fixed codes of the delta instructions.
// ----------------------------------------------------------------------------
package carc_pkg;

    localparam logic [14:0] RUN_LIMIT = 15'h7fff;
    localparam logic [31:0] NO_COPY   = 32'hffff_ffff;
    localparam logic [15:0] END_COUNT = 16'hffff;

    typedef struct packed {
        logic [31:0] copy_start;
        logic [15:0] copy_count;
        logic [15:0] add_count;
        logic        last;
    } result_t;

    typedef struct packed {
        logic held_empty;
    } core_status_t;

endpackage

// ----- sv/carc_core.sv -----
// ----------------------------------------------------------------------------
// carc_core: run state and coalescing logic
// Merges one block reference per transfer into the open instruction and
// produces zero, one or two finished instructions.
// ----------------------------------------------------------------------------
module carc_core
    import carc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic         kind,
    input  logic         from_added,
    input  logic [31:0]  block_index,
    output logic [1:0]   result_num,
    output result_t      result0,
    output result_t      result1,
    output core_status_t status
);

    logic [31:0] run_start_reg, run_start_next;
    logic [14:0] copies_held_reg, copies_held_next;
    logic [14:0] adds_held_reg, adds_held_next;

    logic        held_any;
    logic        emit;
    logic [31:0] next_index;
    logic [14:0] copies_base;
    logic [14:0] adds_base;
    result_t     held_res;
    result_t     end_res;

    assign held_any   = (copies_held_reg != 15'd0) || (adds_held_reg != 15'd0);
    assign next_index = run_start_reg + {17'd0, copies_held_reg};

    always_comb
    begin
        held_res.copy_start = (copies_held_reg == 15'd0) ? NO_COPY : run_start_reg;
        held_res.copy_count = {1'b0, copies_held_reg};
        held_res.add_count  = {1'b0, adds_held_reg};
        held_res.last       = 1'b1;
        end_res.copy_start  = NO_COPY;
        end_res.copy_count  = END_COUNT;
        end_res.add_count   = END_COUNT;
        end_res.last        = 1'b1;
    end

    always_comb
    begin
        emit             = 1'b0;
        result_num       = 2'd0;
        result0          = held_res;
        result1          = end_res;
        run_start_next   = run_start_reg;
        copies_held_next = copies_held_reg;
        adds_held_next   = adds_held_reg;
        copies_base      = copies_held_reg;
        adds_base        = adds_held_reg;
        if (kind)
        begin
            // flush the open instruction, then the end marker; clear the state
            if (held_any)
            begin
                result_num    = 2'd2;
                result0.last  = 1'b0;
            end
            else
            begin
                result_num = 2'd1;
                result0    = end_res;
            end
            run_start_next   = 32'd0;
            copies_held_next = 15'd0;
            adds_held_next   = 15'd0;
        end
        else if (!from_added)
        begin
            emit = ((copies_held_reg != 15'd0) && (block_index != next_index))
                   || (copies_held_reg == RUN_LIMIT) || (adds_held_reg != 15'd0);
            if (emit)
            begin
                result_num  = 2'd1;
                copies_base = 15'd0;
                adds_base   = 15'd0;
            end
            if (copies_base == 15'd0)
                run_start_next = block_index;
            copies_held_next = copies_base + 15'd1;
            adds_held_next   = adds_base;
        end
        else
        begin
            emit = (adds_held_reg == RUN_LIMIT);
            if (emit)
            begin
                result_num  = 2'd1;
                copies_base = 15'd0;
                adds_base   = 15'd0;
            end
            copies_held_next = copies_base;
            adds_held_next   = adds_base + 15'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg   <= 32'd0;
            copies_held_reg <= 15'd0;
            adds_held_reg   <= 15'd0;
        end
        else if (advance)
        begin
            run_start_reg   <= run_start_next;
            copies_held_reg <= copies_held_next;
            adds_held_reg   <= adds_held_next;
        end
    end

    assign status.held_empty = !held_any;

endmodule

// ----- sv/carc_fifo.sv -----
// ----------------------------------------------------------------------------
// carc_fifo: result queue
// Takes up to two results a cycle and hands out one per transfer.
// ----------------------------------------------------------------------------
module carc_fifo
    import carc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  push_num,
    input  result_t     push0,
    input  result_t     push1,
    input  logic        pop,
    output logic        room2,
    output logic        not_empty,
    output result_t     head,
    output logic [2:0]  level
);

    result_t     mem [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg, count_next;
    logic [1:0]  wr_ptr_inc;

    assign wr_ptr_inc = wr_ptr_reg + 2'd1;
    assign count_next = count_reg + {1'b0, push_num} - {2'd0, pop};

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_num == 2'd2)
            mem[wr_ptr_inc] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_num;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    assign room2     = (count_reg <= 3'd2);
    assign not_empty = (count_reg != 3'd0);
    assign head      = mem[rd_ptr_reg];
    assign level     = count_reg;

endmodule

// ----- sv/copy_add_run_coalescer.sv -----
// ----------------------------------------------------------------------------
// copy_add_run_coalescer: block references to copy/add delta instructions
// Takes one block reference (or an end of list) per input transfer and merges
// runs of contiguous original blocks followed by added blocks into
// instructions (copy_start, copy_count, add_count). A copy run closes on a
// break in contiguity, at 32767 copies, or once adds are held; an add run
// closes at 32767. An end item flushes the open instruction (last = 0) and
// then sends the end marker, all ones, with last = 1. Rate: one item per
// cycle sustained; a result passes the input register, then the four-entry
// result queue. The end item of a list with an open instruction yields two
// results, which drain at one per cycle while out_stall is low; input
// stalls only while the queue holds more than two results.
// ----------------------------------------------------------------------------
module copy_add_run_coalescer
    import carc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic        from_added,
    input  logic [31:0] block_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] copy_start,
    output logic [15:0] copy_count,
    output logic [15:0] add_count,
    output logic        last
);

    // input register
    logic         item_valid_reg;
    logic         kind_reg;
    logic         from_added_reg;
    logic [31:0]  block_index_reg;

    logic         advance;
    logic         room2;
    logic [1:0]   result_num;
    logic [1:0]   push_num;
    result_t      result0, result1, head;
    core_status_t status;
    logic         pop;
    logic [2:0]   level;

    // advance the held item into the run logic whenever the queue can take
    // both possible results; otherwise hold it and stall the input side
    assign advance  = item_valid_reg && room2;
    assign in_stall = item_valid_reg && !room2;
    assign push_num = advance ? result_num : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!in_stall)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            kind_reg        <= kind;
            from_added_reg  <= from_added;
            block_index_reg <= block_index;
        end
    end

    carc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .kind        (kind_reg),
        .from_added  (from_added_reg),
        .block_index (block_index_reg),
        .result_num  (result_num),
        .result0     (result0),
        .result1     (result1),
        .status      (status)
    );

    // drop a result from the queue on each output transfer
    assign pop = out_valid && !out_stall;

    carc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_num  (push_num),
        .push0     (result0),
        .push1     (result1),
        .pop       (pop),
        .room2     (room2),
        .not_empty (out_valid),
        .head      (head),
        .level     (level)
    );

    assign copy_start = head.copy_start;
    assign copy_count = head.copy_count;
    assign add_count  = head.add_count;
    assign last       = head.last;

    // an end item leaves the run state empty
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && kind_reg |=> status.held_empty)
        else $error("run state not cleared after end item");

    // a copy or add reference always leaves something held
    a_ref_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !kind_reg |=> !status.held_empty)
        else $error("reference not held after transfer");

    // the result queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= 3'd4)
        else $error("result queue overflow");

    // nothing is pushed while the input side is stalled
    a_stall_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> push_num == 2'd0)
        else $error("result pushed while stalled");

endmodule
